// ===== rtl/assert_macros.svh =====
// assertion helper macros for the framebuffer pager
// used by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lmfb_pkg.sv =====
// shared constants and types for the layered framebuffer pager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lmfb_pkg;
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int BAND          = 8;
    localparam int CHUNK         = 16;
    localparam int COLUMN_LIMIT  = 128;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_FILL   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SKIP  = 2'd2,
        ST_EMPTY = 2'd3
    } res_status_t;

    typedef enum logic [1:0] {
        REG_STATUS_ON = 2'd0,
        REG_TOAST_ON  = 2'd1,
        REG_BOX_W     = 2'd2,
        REG_BOX_H     = 2'd3
    } reg_idx_t;

    localparam logic [1:0] LAYER_TEXT   = 2'd0;
    localparam logic [1:0] LAYER_STATUS = 2'd1;
    localparam logic [1:0] LAYER_TOAST  = 2'd2;
    // no layer: write and fill do nothing, update reads toast
    localparam logic [1:0] LAYER_NONE   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/layered_mono_framebuffer_pager.sv =====
// top level of the layered monochrome framebuffer pager
// depends on lmfb_pkg and assert_macros.svh
//
// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | operation..color
// out     | out       | out_valid/out_ready  | status..last
//
// a pixel write goes through read, write back, result and idle before the next request
// a fill reads and writes back each touched byte of each row, then gives its result and returns to idle
// an update reads all three layers at once, with a read and an accumulate step per pixel row of a
// column; after each chunk of up to 16 columns it emits the chunk and then gives the result
// after reset a clearing pass zeroes all 1024 bytes of each layer; no request is taken meanwhile
// a result waits in the output register while the sequencer stalls for out_ready
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module layered_mono_framebuffer_pager #(
    parameter int SCREEN_WIDTH  = lmfb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lmfb_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        operation,
    input  wire logic [1:0]        layer,
    input  wire logic signed [8:0] pos_x,
    input  wire logic signed [8:0] pos_y,
    input  wire logic [7:0]        rect_width,
    input  wire logic [7:0]        rect_height,
    input  wire logic              color,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [2:0]             page,
    output logic [6:0]             column,
    output logic [4:0]             byte_count,
    output logic [63:0]            bytes_low,
    output logic [63:0]            bytes_high,
    output logic                   last
);
    import lmfb_pkg::*;

    localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
    localparam int DEPTH     = SCREEN_HEIGHT * ROW_BYTES;
    localparam int AW        = $clog2(DEPTH);
    localparam int YW        = $clog2(SCREEN_HEIGHT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WR_RD, S_WR_MOD, S_FL_RD, S_FL_MOD,
        S_UP_RD, S_UP_ACC, S_UP_EMIT, S_OUT
    } state_t;

    // layer memories, one port each
    logic [7:0] mem_text   [DEPTH];
    logic [7:0] mem_status [DEPTH];
    logic [7:0] mem_toast  [DEPTH];

    state_t      state_reg;
    logic        status_on_reg, toast_on_reg;
    logic [7:0]  box_w_reg;
    logic [6:0]  box_h_reg;
    logic [AW:0] clr_reg;

    // latched request
    logic [1:0]  sel_reg;
    logic        color_reg;
    logic [9:0]  xl_reg, xr_reg, yb_reg;
    logic [9:0]  cx_reg, cy_reg;      // walk position
    logic [9:0]  chunk_col_reg;
    logic [4:0]  k_reg;
    logic [2:0]  pg_reg;
    logic [127:0] acc_reg;
    logic [7:0]  rd_text_reg, rd_status_reg, rd_toast_reg;

    // output register
    logic [1:0]  st_o_reg;
    logic [2:0]  pg_o_reg;
    logic [6:0]  col_o_reg;
    logic [4:0]  cnt_o_reg;
    logic [127:0] dat_o_reg;
    logic        last_o_reg, ovalid_reg;
    logic        ret_upd_reg;         // after output, continue update

    // clipping of the incoming request
    logic signed [10:0] x_s, y_s, xr_s, yb_s;
    logic [9:0] xl_c, yt_c, xr_c, yb_c, xr_u;
    always_comb
    begin
        x_s  = 11'(pos_x);
        y_s  = 11'(pos_y);
        xr_s = x_s + 11'(rect_width);
        yb_s = y_s + 11'(rect_height);
        xl_c = (x_s > 0) ? 10'(x_s) : 10'd0;
        yt_c = (y_s > 0) ? 10'(y_s) : 10'd0;
        xr_c = (xr_s < 11'(SCREEN_WIDTH)) ? ((xr_s < 0) ? 10'd0 : 10'(xr_s))
                                          : 10'(SCREEN_WIDTH);
        yb_c = (yb_s < 11'(SCREEN_HEIGHT)) ? ((yb_s < 0) ? 10'd0 : 10'(yb_s))
                                           : 10'(SCREEN_HEIGHT);
        xr_u = (xr_c > 10'(COLUMN_LIMIT)) ? 10'(COLUMN_LIMIT) : xr_c;
    end

    logic on_scr, is_toast, skip;
    assign on_scr = (x_s >= 0) && (y_s >= 0) && (x_s < 11'(SCREEN_WIDTH))
                    && (y_s < 11'(SCREEN_HEIGHT));
    assign is_toast = layer[1];
    assign skip = is_toast != toast_on_reg;

    // shared address unit: row * ROW_BYTES + byte index
    logic [AW-1:0] addr;
    assign addr = AW'(cy_reg[YW-1:0] * ROW_BYTES) + AW'(cx_reg[9:3]);

    // byte modify for write/fill: mask of bits in [xl,xr) within byte
    logic [7:0] fmask, cur_byte, new_byte;
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            fmask[b] = ({cx_reg[9:3], 3'(b)} >= xl_reg) && ({cx_reg[9:3], 3'(b)} < xr_reg);
        end
        case (sel_reg)
            LAYER_TEXT:   cur_byte = rd_text_reg;
            LAYER_STATUS: cur_byte = rd_status_reg;
            default:      cur_byte = rd_toast_reg;
        endcase
        new_byte = color_reg ? (cur_byte | fmask) : (cur_byte & ~fmask);
    end

    // update pixel pick
    logic px;
    logic [9:0] ccol;
    always_comb
    begin
        ccol = chunk_col_reg + 10'(k_reg);
        if (sel_reg[1])
            px = rd_toast_reg[ccol[2:0]];
        else if (status_on_reg && ({2'b0, ccol} < 12'(box_w_reg))
                 && ({2'b0, cy_reg} < 12'(box_h_reg)))
            px = rd_status_reg[ccol[2:0]];
        else
            px = rd_text_reg[ccol[2:0]];
        if (cy_reg >= 10'(SCREEN_HEIGHT))
            px = 1'b0;
    end

    logic [4:0] chunk_cnt;
    logic [9:0] rem;
    assign rem = xr_reg - chunk_col_reg;
    assign chunk_cnt = (rem < 10'(CHUNK)) ? 5'(rem) : 5'(CHUNK);

    logic wr_en;
    assign wr_en = (state_reg == S_WR_MOD) || (state_reg == S_FL_MOD);

    // memories: clear sweep or read-modify-write
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_text[clr_reg[AW-1:0]]   <= 8'd0;
            mem_status[clr_reg[AW-1:0]] <= 8'd0;
            mem_toast[clr_reg[AW-1:0]]  <= 8'd0;
        end
        else if (wr_en)
        begin
            case (sel_reg)
                LAYER_TEXT:   mem_text[addr]   <= new_byte;
                LAYER_STATUS: mem_status[addr] <= new_byte;
                LAYER_TOAST:  mem_toast[addr]  <= new_byte;
                default:      ;
            endcase
        end
        rd_text_reg   <= mem_text[addr];
        rd_status_reg <= mem_status[addr];
        rd_toast_reg  <= mem_toast[addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            status_on_reg <= 1'b1;
            toast_on_reg  <= 1'b0;
            box_w_reg     <= 8'd128;
            box_h_reg     <= 7'd16;
            ovalid_reg    <= 1'b0;
            ret_upd_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_STATUS_ON: status_on_reg <= cfg_data[0];
                    REG_TOAST_ON:  toast_on_reg  <= cfg_data[0];
                    REG_BOX_W:     box_w_reg     <= cfg_data;
                    REG_BOX_H:     box_h_reg     <= cfg_data[6:0];
                    default:       ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sel_reg   <= layer;
                        color_reg <= color;
                        st_o_reg  <= ST_OK;
                        pg_o_reg  <= '0;
                        col_o_reg <= '0;
                        cnt_o_reg <= '0;
                        dat_o_reg <= '0;
                        last_o_reg <= 1'b1;
                        ret_upd_reg <= 1'b0;
                        yb_reg <= yb_c;
                        case (op_t'(operation))
                            OP_WRITE:
                            begin
                                xl_reg <= 10'(x_s);
                                xr_reg <= 10'(x_s) + 10'd1;
                                cx_reg <= 10'(x_s);
                                cy_reg <= 10'(y_s);
                                if (!on_scr)
                                begin
                                    st_o_reg   <= ST_RANGE;
                                    ovalid_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else if (layer == LAYER_NONE)
                                begin
                                    ovalid_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else
                                    state_reg <= S_WR_RD;
                            end
                            OP_FILL:
                            begin
                                xl_reg <= xl_c;
                                xr_reg <= xr_c;
                                cx_reg <= {xl_c[9:3], 3'd0};
                                cy_reg <= yt_c;
                                if (layer == LAYER_NONE || xr_c <= xl_c || yb_c <= yt_c)
                                begin
                                    ovalid_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else
                                    state_reg <= S_FL_RD;
                            end
                            OP_UPDATE:
                            begin
                                xl_reg <= xl_c;
                                xr_reg <= xr_u;
                                chunk_col_reg <= xl_c;
                                k_reg  <= '0;
                                pg_reg <= yt_c[5:3];
                                cy_reg <= {yt_c[9:3], 3'd0};
                                cx_reg <= xl_c;
                                if (skip)
                                begin
                                    st_o_reg   <= ST_SKIP;
                                    ovalid_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else if (xr_u <= xl_c || yb_c <= yt_c)
                                begin
                                    st_o_reg   <= ST_EMPTY;
                                    ovalid_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    acc_reg   <= '0;
                                    state_reg <= S_UP_RD;
                                end
                            end
                            default:
                            begin
                                ovalid_reg <= 1'b1;
                                state_reg  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_WR_RD:  state_reg <= S_WR_MOD;
                S_WR_MOD:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_FL_RD:  state_reg <= S_FL_MOD;
                S_FL_MOD:
                begin
                    // next byte in row, else next row
                    if ((cx_reg + 10'd8) < xr_reg)
                    begin
                        cx_reg    <= cx_reg + 10'd8;
                        state_reg <= S_FL_RD;
                    end
                    else if ((cy_reg + 10'd1) < yb_reg)
                    begin
                        cx_reg    <= {xl_reg[9:3], 3'd0};
                        cy_reg    <= cy_reg + 10'd1;
                        state_reg <= S_FL_RD;
                    end
                    else
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_UP_RD: state_reg <= S_UP_ACC;
                S_UP_ACC:
                begin
                    acc_reg[{k_reg[3:0], cy_reg[2:0]}] <= px;
                    if (cy_reg[2:0] != 3'd7)
                    begin
                        cy_reg    <= cy_reg + 10'd1;
                        state_reg <= S_UP_RD;
                    end
                    else if ((k_reg + 5'd1) < chunk_cnt)
                    begin
                        k_reg     <= k_reg + 5'd1;
                        cx_reg    <= ccol + 10'd1;
                        cy_reg    <= {cy_reg[9:3], 3'd0};
                        state_reg <= S_UP_RD;
                    end
                    else
                        state_reg <= S_UP_EMIT;
                end
                S_UP_EMIT:
                begin
                    st_o_reg   <= ST_OK;
                    pg_o_reg   <= pg_reg;
                    col_o_reg  <= chunk_col_reg[6:0];
                    cnt_o_reg  <= chunk_cnt;
                    dat_o_reg  <= acc_reg;
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                    acc_reg    <= '0;
                    k_reg      <= '0;
                    if ((chunk_col_reg + 10'(CHUNK)) < xr_reg)
                    begin
                        chunk_col_reg <= chunk_col_reg + 10'(CHUNK);
                        cx_reg        <= chunk_col_reg + 10'(CHUNK);
                        cy_reg        <= {cy_reg[9:3], 3'd0};
                        last_o_reg    <= 1'b0;
                        ret_upd_reg   <= 1'b1;
                    end
                    else if ({cy_reg[9:3], 3'd0} + 10'd8 < yb_reg)
                    begin
                        chunk_col_reg <= xl_reg;
                        cx_reg        <= xl_reg;
                        cy_reg        <= {cy_reg[9:3], 3'd0} + 10'd8;
                        pg_reg        <= pg_reg + 3'd1;
                        last_o_reg    <= 1'b0;
                        ret_upd_reg   <= 1'b1;
                    end
                    else
                    begin
                        last_o_reg  <= 1'b1;
                        ret_upd_reg <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= ret_upd_reg ? S_UP_RD : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign status     = st_o_reg;
    assign page       = pg_o_reg;
    assign column     = col_o_reg;
    assign byte_count = cnt_o_reg;
    assign bytes_low  = dat_o_reg[63:0];
    assign bytes_high = dat_o_reg[127:64];
    assign last       = last_o_reg;

    `CHK_IMPL(a_out_state, clk, rst_n, out_valid, state_reg == S_OUT, "result outside output state")
    `CHK_IMPL(a_no_in_busy, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
    `CHK_NEXT(a_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed after request")
    `CHK_IMPL(a_cnt, clk, rst_n, out_valid, byte_count <= 5'd16, "byte count above chunk")
endmodule
`default_nettype wire

// ===== test/layered_mono_framebuffer_pager_tb.sv =====
// self-checking testbench for the layered monochrome framebuffer pager
// depends on lmfb_pkg and the top level layered_mono_framebuffer_pager
`timescale 1ns / 1ps
module layered_mono_framebuffer_pager_tb;
    import lmfb_pkg::*;

    localparam int SW = 128;
    localparam int SH = 64;
    localparam int ROWB = SW / 8;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]        st;
        logic [2:0]        pg;
        logic [6:0]        col;
        logic [4:0]        cnt;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic              lst;
    } frag_t;

    typedef struct {
        op_t               op;
        logic [1:0]        lay;
        logic signed [8:0] x;
        logic signed [8:0] y;
        logic [7:0]        w;
        logic [7:0]        h;
        logic              c;
        int                want_st;   // -1 means use predictor only
    } req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic [1:0] layer = '0;
    logic signed [8:0] pos_x = '0;
    logic signed [8:0] pos_y = '0;
    logic [7:0] rect_width = '0;
    logic [7:0] rect_height = '0;
    logic color = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [2:0] page;
    logic [6:0] column;
    logic [4:0] byte_count;
    logic [63:0] bytes_low;
    logic [63:0] bytes_high;
    logic last;

    layered_mono_framebuffer_pager uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .layer(layer), .pos_x(pos_x), .pos_y(pos_y),
        .rect_width(rect_width), .rect_height(rect_height), .color(color),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .page(page), .column(column), .byte_count(byte_count),
        .bytes_low(bytes_low), .bytes_high(bytes_high), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the layers and registers
    logic [7:0] text_mem [SH*ROWB];
    logic [7:0] stat_mem [SH*ROWB];
    logic [7:0] toast_mem [SH*ROWB];
    logic       sh_status_on;
    logic       sh_toast_on;
    logic [7:0] sh_box_w;
    logic [6:0] sh_box_h;

    frag_t pending_frags[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    out_stall_mode = 0;

    function automatic bit on_screen(int x, int y);
        return x >= 0 && y >= 0 && x < SW && y < SH;
    endfunction

    function automatic logic get_pix(int sel, int x, int y);
        int idx;
        if (!on_screen(x, y))
            return 1'b0;
        idx = y * ROWB + x / 8;
        case (sel)
            0: return text_mem[idx][x % 8];
            1: return stat_mem[idx][x % 8];
            default: return toast_mem[idx][x % 8];
        endcase
    endfunction

    task automatic put_pix(int sel, int x, int y, logic c);
        int idx;
        if (!on_screen(x, y))
            return;
        idx = y * ROWB + x / 8;
        case (sel)
            0: text_mem[idx][x % 8] = c;
            1: stat_mem[idx][x % 8] = c;
            2: toast_mem[idx][x % 8] = c;
            default: ;
        endcase
    endtask

    function automatic logic shown_pix(bit toast, int x, int y);
        if (toast)
            return get_pix(2, x, y);
        if (sh_status_on && x >= 0 && y >= 0 && x < sh_box_w && y < sh_box_h)
            return get_pix(1, x, y);
        return get_pix(0, x, y);
    endfunction

    function automatic frag_t flag_frag(res_status_t s);
        frag_t f;
        f = '0;
        f.st = s;
        f.lst = 1'b1;
        return f;
    endfunction

    // compute the pages a request produces and apply its writes
    task automatic predict_pages(req_t r);
        int x, y, w, h, xl, yt, xr, yb, p, col, k, i;
        bit toast;
        frag_t f;
        logic [7:0] b;
        x = r.x; y = r.y; w = r.w; h = r.h;
        xl = x > 0 ? x : 0;
        yt = y > 0 ? y : 0;
        xr = x + w < SW ? x + w : SW;
        yb = y + h < SH ? y + h : SH;
        case (r.op)
            OP_WRITE:
            begin
                if (!on_screen(x, y))
                    pending_frags.push_back(flag_frag(ST_RANGE));
                else
                begin
                    put_pix(r.lay, x, y, r.c);
                    pending_frags.push_back(flag_frag(ST_OK));
                end
            end
            OP_FILL:
            begin
                for (int j = yt; j < yb; j++)
                    for (int q = xl; q < xr; q++)
                        put_pix(r.lay, q, j, r.c);
                pending_frags.push_back(flag_frag(ST_OK));
            end
            OP_UPDATE:
            begin
                toast = r.lay[1];
                if (toast != sh_toast_on)
                    pending_frags.push_back(flag_frag(ST_SKIP));
                else
                begin
                    if (xr > COLUMN_LIMIT)
                        xr = COLUMN_LIMIT;
                    if (xr <= xl || yb <= yt)
                        pending_frags.push_back(flag_frag(ST_EMPTY));
                    else
                    begin
                        for (p = yt / 8; p <= (yb - 1) / 8; p++)
                            for (col = xl; col < xr; col += CHUNK)
                            begin
                                f = '0;
                                f.pg = 3'(p);
                                f.col = 7'(col);
                                f.cnt = 5'((xr - col < CHUNK) ? xr - col : CHUNK);
                                for (k = 0; k < f.cnt; k++)
                                begin
                                    for (i = 0; i < 8; i++)
                                        b[i] = shown_pix(toast, col + k, p * 8 + i);
                                    if (k < 8)
                                        f.lo[8*k +: 8] = b;
                                    else
                                        f.hi[8*(k-8) +: 8] = b;
                                end
                                pending_frags.push_back(f);
                            end
                        f = pending_frags[pending_frags.size() - 1];
                        f.lst = 1'b1;
                        pending_frags[pending_frags.size() - 1] = f;
                    end
                end
            end
            default: pending_frags.push_back(flag_frag(ST_OK));
        endcase
    endtask

    // result checker, runs on every rising edge
    always @(posedge clk)
    begin
        frag_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, page, column, byte_count, bytes_low, bytes_high, last};
            if (pending_frags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_frags.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp st=%0d pg=%0d col=%0d cnt=%0d last=%0d",
                            want.st, want.pg, want.col, want.cnt, want.lst);
                        $display("    exp lo=%h hi=%h", want.lo, want.hi);
                        $display("    got st=%0d pg=%0d col=%0d cnt=%0d last=%0d",
                            got.st, got.pg, got.col, got.cnt, got.lst);
                        $display("    got lo=%h hi=%h", got.lo, got.hi);
                    end
                end
            end
        end
    end

    // watchdog on accepted requests, config writes and results
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            out_stall_mode <= ~out_stall_mode;
        if (out_stall_mode)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    task automatic write_reg(reg_idx_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_STATUS_ON: sh_status_on = val[0];
            REG_TOAST_ON:  sh_toast_on = val[0];
            REG_BOX_W:     sh_box_w = val;
            default:       sh_box_h = val[6:0];
        endcase
    endtask

    task automatic drain();
        while (pending_frags.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // one request, valid held until taken
    task automatic send_req(req_t r);
        int n0;
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= r.op;
        layer <= r.lay;
        pos_x <= r.x;
        pos_y <= r.y;
        rect_width <= r.w;
        rect_height <= r.h;
        color <= r.c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n0 = pending_frags.size();
        predict_pages(r);
        if (r.want_st >= 0 && pending_frags[n0].st != r.want_st)
        begin
            mismatches++;
            $display("table row status %0d disagrees with predictor", r.want_st);
        end
    endtask

    task automatic idle_gap();
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    function automatic req_t rand_req();
        req_t r;
        int sel;
        sel = $urandom_range(0, 99);
        r.op = op_t'(sel < 35 ? OP_WRITE : sel < 60 ? OP_FILL : sel < 95 ? OP_UPDATE : OP_NONE);
        r.lay = $urandom_range(0, 9) == 0 ? LAYER_NONE : 2'($urandom_range(0, 2));
        r.c = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8)
        begin
            r.x = 9'($urandom_range(0, SW - 1));
            r.y = 9'($urandom_range(0, SH - 1));
        end
        else
        begin
            r.x = 9'($urandom);
            r.y = 9'($urandom);
        end
        if (r.op == OP_UPDATE && $urandom_range(0, 3) != 0)
        begin
            r.w = 8'($urandom_range(0, 40));
            r.h = 8'($urandom_range(0, 20));
        end
        else
        begin
            r.w = 8'($urandom);
            r.h = 8'($urandom);
        end
        r.want_st = -1;
        return r;
    endfunction

    req_t table_rows[$];
    req_t rq;
    int   burst;

    initial
    begin
        for (int i = 0; i < SH * ROWB; i++)
        begin
            text_mem[i] = '0;
            stat_mem[i] = '0;
            toast_mem[i] = '0;
        end
        sh_status_on = 1'b1;
        sh_toast_on = 1'b0;
        sh_box_w = 8'd128;
        sh_box_h = 7'd16;

        // directed stimulus table
        table_rows = '{
            '{OP_UPDATE, LAYER_TEXT,   0,    0,    128, 64,  0, -1},
            '{OP_UPDATE, LAYER_TOAST,  0,    0,    8,   8,   0, ST_SKIP},
            '{OP_WRITE,  LAYER_TEXT,   -256, 0,    0,   0,   1, ST_RANGE},
            '{OP_WRITE,  LAYER_TEXT,   0,    255,  0,   0,   1, ST_RANGE},
            '{OP_WRITE,  LAYER_TEXT,   128,  0,    0,   0,   1, ST_RANGE},
            '{OP_WRITE,  LAYER_TEXT,   127,  63,   0,   0,   1, ST_OK},
            '{OP_WRITE,  LAYER_STATUS, 0,    0,    0,   0,   1, ST_OK},
            '{OP_WRITE,  LAYER_NONE,   5,    5,    0,   0,   1, ST_OK},
            '{OP_FILL,   LAYER_TEXT,   -256, -256, 255, 255, 1, ST_OK},
            '{OP_FILL,   LAYER_STATUS, 10,   3,    0,   9,   1, ST_OK},
            '{OP_FILL,   LAYER_STATUS, 4,    2,    30,  20,  0, ST_OK},
            '{OP_FILL,   LAYER_TOAST,  100,  50,   255, 255, 1, ST_OK},
            '{OP_FILL,   LAYER_NONE,   0,    0,    255, 255, 0, ST_OK},
            '{OP_NONE,   LAYER_TEXT,   255,  255,  255, 255, 1, ST_OK},
            '{OP_UPDATE, LAYER_TEXT,   -256, -256, 255, 255, 0, -1},
            '{OP_UPDATE, LAYER_STATUS, 120,  60,   255, 255, 0, -1},
            '{OP_UPDATE, LAYER_TEXT,   255,  0,    10,  10,  0, ST_EMPTY},
            '{OP_UPDATE, LAYER_TEXT,   5,    5,    0,   10,  0, ST_EMPTY},
            '{OP_UPDATE, LAYER_TEXT,   3,    -2,   17,  13,  0, -1}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
            send_req(table_rows[i]);
        idle_gap();
        drain();

        // toast mode, status off, box extremes
        write_reg(REG_TOAST_ON, 8'd1);
        write_reg(REG_STATUS_ON, 8'd0);
        rq = '{OP_UPDATE, LAYER_TOAST, 96, 48, 255, 255, 0, -1};
        send_req(rq);
        rq = '{OP_UPDATE, LAYER_TEXT, 0, 0, 8, 8, 0, ST_SKIP};
        send_req(rq);
        rq = '{OP_UPDATE, LAYER_NONE, 0, 0, 20, 9, 0, -1};
        send_req(rq);
        idle_gap();
        drain();
        write_reg(REG_TOAST_ON, 8'd0);
        write_reg(REG_STATUS_ON, 8'd1);
        write_reg(REG_BOX_W, 8'd0);
        write_reg(REG_BOX_H, 8'd64);

        // random phases with register changes between them
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int n = 0; n < 50; )
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 50; b++, n++)
                    send_req(rand_req());
                if ($urandom_range(0, 2) != 0)
                    idle_gap();
            end
            idle_gap();
            // sender holds off until everything is back
            drain();
            write_reg(REG_STATUS_ON, 8'($urandom_range(0, 1)));
            write_reg(REG_TOAST_ON, {7'd0, ph % 3 == 2});
            write_reg(REG_BOX_W, ph == 1 ? 8'd255 : ph == 3 ? 8'd128 : 8'($urandom));
            write_reg(REG_BOX_H, ph == 1 ? 8'd127 : ph == 3 ? 8'd0 : 8'($urandom_range(0, 64)));
        end

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
